### rtl/ffha_pkg.sv
// ============================================================================
// ffha_pkg
// Shared types and codes for the first-fit heap allocator: transaction
// payloads, operation and status codes, sequencer states, table entry layout.
// ============================================================================
package ffha_pkg;

    // Fixed field widths
    localparam int ADDR_W  = 16;
    localparam int SIZE_W  = 16;
    localparam int LIMIT_W = 17;
    localparam int PROD_W  = 32;

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_FREE    = 2'd1,
        FUNC_REALLOC = 2'd2,
        FUNC_CALLOC  = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_NULL       = 3'd1,
        STAT_HEAP_FULL  = 3'd2,
        STAT_TABLE_FULL = 3'd3,
        STAT_UNKNOWN    = 3'd4,
        STAT_OVERFLOW   = 3'd5
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_SCAN,
        S_FREE_OLD,
        S_RESP
    } state_t;

    // Configuration register byte addresses
    localparam logic [2:0] REG_HEAP_LIMIT = 3'd0;

    // Request transaction
    typedef struct packed {
        func_t              func;
        logic [SIZE_W-1:0]  size;
        logic [SIZE_W-1:0]  count;
        logic [ADDR_W-1:0]  address;
    } req_t;

    // Response transaction
    typedef struct packed {
        logic [ADDR_W-1:0]  result_address;
        status_t            status;
        logic               trimmed;
    } rsp_t;

    // One block table entry
    typedef struct packed {
        logic [ADDR_W-1:0]  offset;
        logic [SIZE_W-1:0]  size;
        logic               free;
    } entry_t;

endpackage

### rtl/first_fit_heap_allocator_unit.sv
// ============================================================================
// first_fit_heap_allocator_unit
// First-fit heap allocator over a block table held in a single-port memory,
// walked one entry per cycle by a small sequencer.
// ============================================================================
//
// Usage:
//   req channel (req_valid/req_stall/req) carries one operation per
//   transaction: alloc, free, realloc or calloc. rsp channel
//   (rsp_valid/rsp_stall/rsp) returns exactly one result per request.
//   req_stall is high while an operation is in progress; one operation is
//   worked at a time.
//   Each request passes a setup state (calloc the multiplier state first),
//   then the table walk unless setup settles the result; the walk reads one
//   table entry at a time (up to entry count plus one), limited by the single
//   memory read port. Realloc that moves a block walks the table twice, then
//   frees the old block. The result state loads the output register.
//   The output register lets the next request be accepted while a result
//   waits; if rsp_stall holds, the finished result waits in the sequencer.
//   Reset empties the heap (entry count and heap top zero), sets heap_limit
//   to 65536; table contents need no clearing.
//   The user must write heap_limit over the APB port at byte address 0 only
//   while idle; the block itself does not enforce this.
//
module first_fit_heap_allocator_unit #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  ffha_pkg::req_t        req,
    // response channel
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output ffha_pkg::rsp_t        rsp,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import ffha_pkg::*;

    localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int LIM_CAP = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;

    localparam logic [CNT_W-1:0]   MAX_CNT = CNT_W'(MAX_BLOCKS);
    localparam logic [LIMIT_W-1:0] CAP17   = LIMIT_W'(LIM_CAP);
    localparam logic [ADDR_W-1:0]  HDR16   = ADDR_W'(HEADER_BYTES);
    localparam logic [LIMIT_W-1:0] HDR17   = LIMIT_W'(HEADER_BYTES);
    localparam logic [LIMIT_W:0]   HDR18   = (LIMIT_W + 1)'(HEADER_BYTES);

    // Control state
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [LIMIT_W-1:0]   heap_top_reg, heap_top_next;
    logic [LIMIT_W-1:0]   heap_limit_reg, heap_limit_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    // Working registers
    req_t                 op_reg, op_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [SIZE_W-1:0]    req_size_reg, req_size_next;
    logic [LIMIT_W:0]     top_new_reg, top_new_next;
    logic [LIMIT_W-1:0]   lim_reg, lim_next;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 scan_find_reg, scan_find_next;
    logic                 pend_free_reg, pend_free_next;
    logic [CNT_W-1:0]     old_idx_reg, old_idx_next;
    entry_t               old_entry_reg, old_entry_next;
    logic [ADDR_W-1:0]    res_addr_reg, res_addr_next;
    status_t              res_status_reg, res_status_next;
    logic                 res_trim_reg, res_trim_next;
    rsp_t                 rsp_reg, rsp_next;

    // Block table memory
    entry_t               table_mem [MAX_BLOCKS];
    entry_t               rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wa;
    entry_t               mem_wd;

    // Shared free-block unit signals
    logic [CNT_W-1:0]     trim_idx;
    entry_t               trim_entry;
    logic [LIMIT_W:0]     trim_diff;
    logic                 trim_last;

    // Scan helpers
    logic [CNT_W-1:0]     scan_inc;
    logic                 hit_find;
    logic                 hit_alloc;
    logic [SIZE_W-1:0]    alloc_size;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEAP_LIMIT[2]) ? 32'(heap_limit_reg) : 32'd0;

    always_comb
    begin
        heap_limit_next = heap_limit_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_HEAP_LIMIT[2]))
        begin
            heap_limit_next = pwdata[LIMIT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake outputs
    // ------------------------------------------------------------------
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Shared free unit: operates on the found entry or on the old block
    // ------------------------------------------------------------------
    assign trim_idx   = (state_reg == S_FREE_OLD) ? old_idx_reg : scan_idx_reg;
    assign trim_entry = (state_reg == S_FREE_OLD) ? old_entry_reg : rd_data_reg;
    assign trim_last  = ((trim_idx + CNT_W'(1)) == count_reg);
    assign trim_diff  = {1'b0, heap_top_reg} - HDR18 - (LIMIT_W + 1)'(trim_entry.size);

    // Scan compare
    assign scan_inc  = scan_idx_reg + CNT_W'(1);
    assign hit_find  = (({1'b0, rd_data_reg.offset} + HDR17) == {1'b0, op_reg.address});
    assign hit_alloc = rd_data_reg.free && (rd_data_reg.size >= req_size_reg);
    assign alloc_size = (op_reg.func == FUNC_CALLOC) ? prod_reg[SIZE_W-1:0] : op_reg.size;

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        heap_top_next   = heap_top_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        op_next         = op_reg;
        prod_next       = prod_reg;
        req_size_next   = req_size_reg;
        top_new_next    = top_new_reg;
        lim_next        = lim_reg;
        scan_idx_next   = scan_idx_reg;
        scan_find_next  = scan_find_reg;
        pend_free_next  = pend_free_reg;
        old_idx_next    = old_idx_reg;
        old_entry_next  = old_entry_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        res_trim_next   = res_trim_reg;
        rsp_next        = rsp_reg;
        rd_addr         = '0;
        mem_we          = 1'b0;
        mem_wa          = trim_idx[IDX_W-1:0];
        mem_wd          = '{offset: trim_entry.offset, size: trim_entry.size, free: 1'b1};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req;
                    state_next = (req.func == FUNC_CALLOC) ? S_MUL : S_PREP;
                end
            end

            // calloc element product
            S_MUL:
            begin
                prod_next  = PROD_W'(op_reg.count) * PROD_W'(op_reg.size);
                state_next = S_PREP;
            end

            // classify request, precompute append top, start the walk at entry 0
            S_PREP:
            begin
                res_addr_next   = '0;
                res_status_next = STAT_OK;
                res_trim_next   = 1'b0;
                pend_free_next  = 1'b0;
                scan_idx_next   = '0;
                scan_find_next  = 1'b0;
                req_size_next   = alloc_size;
                top_new_next    = {1'b0, heap_top_reg} + HDR18 + (LIMIT_W + 1)'(alloc_size);
                lim_next        = (heap_limit_reg < CAP17) ? heap_limit_reg : CAP17;
                state_next      = S_SCAN;
                unique case (op_reg.func)
                    FUNC_ALLOC:
                    begin
                        if (op_reg.size == '0)
                        begin
                            res_status_next = STAT_NULL;
                            state_next      = S_RESP;
                        end
                    end
                    FUNC_FREE:
                    begin
                        if (op_reg.address == '0)
                        begin
                            res_status_next = STAT_NULL;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            scan_find_next = 1'b1;
                        end
                    end
                    FUNC_REALLOC:
                    begin
                        if (op_reg.size == '0)
                        begin
                            res_status_next = STAT_NULL;
                            state_next      = S_RESP;
                        end
                        else if (op_reg.address != '0)
                        begin
                            scan_find_next = 1'b1;
                        end
                    end
                    FUNC_CALLOC:
                    begin
                        if ((op_reg.count == '0) || (op_reg.size == '0))
                        begin
                            res_status_next = STAT_NULL;
                            state_next      = S_RESP;
                        end
                        else if (prod_reg[PROD_W-1:SIZE_W] != '0)
                        begin
                            res_status_next = STAT_OVERFLOW;
                            state_next      = S_RESP;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            // table walk: rd_data_reg holds entry scan_idx_reg
            S_SCAN:
            begin
                priority if (scan_idx_reg >= count_reg)
                begin
                    priority if (scan_find_reg)
                    begin
                        res_status_next = STAT_UNKNOWN;
                        state_next      = S_RESP;
                    end
                    else if (count_reg >= MAX_CNT)
                    begin
                        res_status_next = STAT_TABLE_FULL;
                        state_next      = S_RESP;
                    end
                    else if (top_new_reg > {1'b0, lim_reg})
                    begin
                        res_status_next = STAT_HEAP_FULL;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        // append a new block at the heap top
                        mem_we          = 1'b1;
                        mem_wa          = count_reg[IDX_W-1:0];
                        mem_wd          = '{offset: heap_top_reg[ADDR_W-1:0],
                                            size: req_size_reg, free: 1'b0};
                        count_next      = scan_inc;
                        heap_top_next   = top_new_reg[LIMIT_W-1:0];
                        res_addr_next   = heap_top_reg[ADDR_W-1:0] + HDR16;
                        res_status_next = STAT_OK;
                        state_next      = pend_free_reg ? S_FREE_OLD : S_RESP;
                    end
                end
                else if (scan_find_reg && hit_find)
                begin
                    if (op_reg.func == FUNC_FREE)
                    begin
                        if (trim_last)
                        begin
                            heap_top_next = trim_diff[LIMIT_W] ? '0 : trim_diff[LIMIT_W-1:0];
                            count_next    = trim_idx;
                            res_trim_next = 1'b1;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                        end
                        state_next = S_RESP;
                    end
                    else if (rd_data_reg.size >= req_size_reg)
                    begin
                        // realloc in place
                        res_addr_next = op_reg.address;
                        state_next    = S_RESP;
                    end
                    else
                    begin
                        // realloc must move: remember old block, rescan for a fit
                        old_entry_next = rd_data_reg;
                        old_idx_next   = scan_idx_reg;
                        pend_free_next = 1'b1;
                        scan_find_next = 1'b0;
                        scan_idx_next  = '0;
                        rd_addr        = '0;
                    end
                end
                else if (!scan_find_reg && hit_alloc)
                begin
                    // reuse first free block that fits
                    mem_we          = 1'b1;
                    mem_wa          = scan_idx_reg[IDX_W-1:0];
                    mem_wd          = '{offset: rd_data_reg.offset,
                                        size: rd_data_reg.size, free: 1'b0};
                    res_addr_next   = rd_data_reg.offset + HDR16;
                    res_status_next = STAT_OK;
                    state_next      = pend_free_reg ? S_FREE_OLD : S_RESP;
                end
                else
                begin
                    scan_idx_next = scan_inc;
                    rd_addr       = scan_inc[IDX_W-1:0];
                end
            end

            // release the block a realloc moved away from
            S_FREE_OLD:
            begin
                if (trim_last)
                begin
                    heap_top_next = trim_diff[LIMIT_W] ? '0 : trim_diff[LIMIT_W-1:0];
                    count_next    = trim_idx;
                    res_trim_next = 1'b1;
                end
                else
                begin
                    mem_we = 1'b1;
                end
                state_next = S_RESP;
            end

            // hand result to the output register once it is free
            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = '{result_address: res_addr_reg,
                                       status: res_status_reg, trimmed: res_trim_reg};
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            heap_top_reg   <= '0;
            heap_limit_reg <= LIMIT_W'(65536);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            heap_top_reg   <= heap_top_next;
            heap_limit_reg <= heap_limit_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload and working registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        prod_reg       <= prod_next;
        req_size_reg   <= req_size_next;
        top_new_reg    <= top_new_next;
        lim_reg        <= lim_next;
        scan_idx_reg   <= scan_idx_next;
        scan_find_reg  <= scan_find_next;
        pend_free_reg  <= pend_free_next;
        old_idx_reg    <= old_idx_next;
        old_entry_reg  <= old_entry_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        res_trim_reg   <= res_trim_next;
        rsp_reg        <= rsp_next;
    end

    // ------------------------------------------------------------------
    // Block table: one write, one registered read per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("entry count exceeds table depth");

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        heap_top_reg <= CAP17)
        else $error("heap top beyond heap size");

    a_rsp_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("response loaded outside result state");

    a_trim_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.trimmed) |-> (rsp_reg.status == STAT_OK))
        else $error("trimmed flagged on a failed transaction");

endmodule

### bench/heap_alloc_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// heap_alloc_checker
// Passive checker for the first-fit heap allocator. It watches the request,
// response and configuration channels, keeps its own copy of the block table,
// heap top and heap limit, predicts one response per accepted request and
// compares each accepted response field by field with the oldest prediction.
// ============================================================================
module heap_alloc_checker #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  ffha_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  ffha_pkg::rsp_t rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    input  logic           pready,
    output int             fail_count,
    output int             outstanding
);
    import ffha_pkg::*;

    localparam int REPORT_MAX = 10;

    // Shadow block table and heap bookkeeping
    logic [ADDR_W-1:0]  blk_offset [MAX_BLOCKS];
    logic [SIZE_W-1:0]  blk_size   [MAX_BLOCKS];
    logic               blk_free   [MAX_BLOCKS];
    int unsigned        blk_count;
    int unsigned        top_bytes;
    logic [LIMIT_W-1:0] limit_reg;

    rsp_t pending_rsps [$];
    int   mismatch_count = 0;

    assign fail_count = mismatch_count;

    // Effective heap limit: register clamped to the heap size and 64 KiB
    function automatic int unsigned usable_limit();
        int unsigned lim;
        lim = 32'(limit_reg);
        if (lim > HEAP_BYTES) lim = HEAP_BYTES;
        if (lim > 65536) lim = 65536;
        return lim;
    endfunction

    // Table index whose user address matches, or -1
    function automatic int lookup_block(input int unsigned addr);
        for (int i = 0; i < blk_count && i < MAX_BLOCKS; i++)
        begin
            if (blk_offset[i] + HEADER_BYTES == addr) return i;
        end
        return -1;
    endfunction

    // First fit over free entries, else append at the heap top
    function automatic logic [ADDR_W-1:0] alloc_block(input int unsigned nbytes,
                                                      output status_t st);
        int unsigned new_top;
        int unsigned n;
        if (nbytes == 0)
        begin
            st = STAT_NULL;
            return '0;
        end
        for (int i = 0; i < blk_count && i < MAX_BLOCKS; i++)
        begin
            if (blk_free[i] && blk_size[i] >= nbytes)
            begin
                blk_free[i] = 1'b0;
                st = STAT_OK;
                return ADDR_W'(blk_offset[i] + HEADER_BYTES);
            end
        end
        // table full is checked ahead of heap full
        if (blk_count >= MAX_BLOCKS)
        begin
            st = STAT_TABLE_FULL;
            return '0;
        end
        new_top = top_bytes + HEADER_BYTES + nbytes;
        if (new_top > usable_limit())
        begin
            st = STAT_HEAP_FULL;
            return '0;
        end
        n = blk_count;
        blk_offset[n] = top_bytes[ADDR_W-1:0];
        blk_size[n]   = nbytes[SIZE_W-1:0];
        blk_free[n]   = 1'b0;
        blk_count     = n + 1;
        top_bytes     = new_top;
        st = STAT_OK;
        return ADDR_W'(blk_offset[n] + HEADER_BYTES);
    endfunction

    // Last block gives its span back to the heap top; others are marked free
    function automatic logic release_block(input int idx);
        int unsigned span;
        if (idx + 1 == blk_count)
        begin
            span = HEADER_BYTES + blk_size[idx];
            top_bytes = (top_bytes >= span) ? top_bytes - span : 0;
            blk_count = idx;
            return 1'b1;
        end
        blk_free[idx] = 1'b1;
        return 1'b0;
    endfunction

    // Expected response of one request; updates the shadow state
    function automatic rsp_t predicted_response(input req_t r);
        rsp_t              o;
        status_t           st;
        logic [ADDR_W-1:0] res;
        logic              trim;
        int                idx;
        int unsigned       cnt_u;
        int unsigned       sz_u;
        int unsigned       product;
        res   = '0;
        st    = STAT_OK;
        trim  = 1'b0;
        cnt_u = 32'(r.count);
        sz_u  = 32'(r.size);
        product = cnt_u * sz_u;
        case (r.func)
            FUNC_ALLOC: res = alloc_block(sz_u, st);
            FUNC_FREE:
            begin
                if (r.address == 0)
                begin
                    st = STAT_NULL;
                end
                else
                begin
                    idx = lookup_block(32'(r.address));
                    if (idx < 0) st = STAT_UNKNOWN;
                    else trim = release_block(idx);
                end
            end
            FUNC_REALLOC:
            begin
                // null address or zero size acts as a plain alloc
                if (r.address == 0 || r.size == 0)
                begin
                    res = alloc_block(sz_u, st);
                end
                else
                begin
                    idx = lookup_block(32'(r.address));
                    if (idx < 0)
                    begin
                        st = STAT_UNKNOWN;
                    end
                    else if (blk_size[idx] >= r.size)
                    begin
                        res = r.address;
                    end
                    else
                    begin
                        res = alloc_block(sz_u, st);
                        if (st == STAT_OK) trim = release_block(idx);
                    end
                end
            end
            default:
            begin
                if (r.count == 0 || r.size == 0) st = STAT_NULL;
                else if (product > 32'hFFFF) st = STAT_OVERFLOW;
                else res = alloc_block(product, st);
            end
        endcase
        o.result_address = res;
        o.status         = st;
        o.trimmed        = trim;
        return o;
    endfunction

    // Channel monitor: config writes, response compare, request prediction
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            blk_count = 0;
            top_bytes = 0;
            limit_reg = 17'h10000;
            pending_rsps.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == REG_HEAP_LIMIT)
                limit_reg = pwdata[LIMIT_W-1:0];

            if (rsp_valid && !rsp_stall)
            begin
                if (pending_rsps.size() == 0)
                begin
                    if (mismatch_count < REPORT_MAX)
                        $display("unexpected response: addr=%0d status=%0d trimmed=%0d",
                                 rsp.result_address, rsp.status, rsp.trimmed);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_rsps.pop_front();
                    if (rsp.result_address !== want.result_address ||
                        rsp.status !== want.status ||
                        rsp.trimmed !== want.trimmed)
                    begin
                        if (mismatch_count < REPORT_MAX)
                            $display({"response mismatch: expected addr=%0d status=%0d ",
                                      "trimmed=%0d, got addr=%0d status=%0d trimmed=%0d"},
                                     want.result_address, want.status, want.trimmed,
                                     rsp.result_address, rsp.status, rsp.trimmed);
                        mismatch_count++;
                    end
                end
            end

            if (req_valid && !req_stall)
                pending_rsps.push_back(predicted_response(req));

            outstanding <= pending_rsps.size();
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Testbench for the first-fit heap allocator. Drives a directed sequence of
// corner cases, then phases of random alloc/free/realloc/calloc traffic under
// several heap limits, with random gaps and stalls on both channels and one
// long response hold-off. Checking is done by heap_alloc_checker.
// ============================================================================
module tb_top;
    import ffha_pkg::*;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 16;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AT      = 350;
    localparam int DRAIN_CYCLES = 2 * MAX_BLOCKS + 8;
    localparam int NUM_PHASES   = 7;
    localparam int POOL_DEPTH   = 64;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          outstanding;

    // Recently returned user addresses, reused as free/realloc targets
    logic [ADDR_W-1:0] live_addrs [$];
    bit                req_gaps = 1'b1;
    int                items_sent = 0;

    first_fit_heap_allocator_unit #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    heap_alloc_checker #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic req_t pack_req(input func_t f, input logic [15:0] sz,
                                      input logic [15:0] cnt, input logic [15:0] addr);
        req_t r;
        r.func    = f;
        r.size    = sz;
        r.count   = cnt;
        r.address = addr;
        return r;
    endfunction

    // Random request; free_pct sets the share of frees in this phase
    function automatic req_t make_item(input int free_pct);
        req_t r;
        int   pick;
        int   s;
        int   a;
        r.count = 16'($urandom);
        s = $urandom_range(0, 99);
        if (s < 3) r.size = '0;
        else if (s < 73) r.size = 16'($urandom_range(1, 64));
        else if (s < 93) r.size = 16'($urandom_range(1, 2048));
        else r.size = 16'($urandom);
        a = $urandom_range(0, 99);
        if (a < 80 && live_addrs.size() != 0)
            r.address = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        else if (a < 85) r.address = '0;
        else r.address = 16'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            // noise: every field unconstrained
            r.func    = func_t'($urandom_range(0, 3));
            r.size    = 16'($urandom);
            r.address = 16'($urandom);
        end
        else if (pick < 5 + free_pct)
        begin
            r.func = FUNC_FREE;
        end
        else
        begin
            s = $urandom_range(0, 99);
            if (s < 50)
            begin
                r.func = FUNC_ALLOC;
            end
            else if (s < 75)
            begin
                r.func = FUNC_REALLOC;
            end
            else
            begin
                r.func = FUNC_CALLOC;
                if ($urandom_range(0, 9) < 8)
                begin
                    r.count = 16'($urandom_range(1, 16));
                    r.size  = 16'($urandom_range(0, 64));
                end
            end
        end
        return r;
    endfunction

    // One request transaction with a random lead-in gap
    task automatic send_req(input req_t item);
        int gap;
        if (items_sent % 40 == 0) req_gaps = ($urandom_range(0, 3) != 0);
        items_sent++;
        gap = req_gaps ? $urandom_range(0, 16) : 0;
        repeat (gap)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (req_stall);
    endtask

    // APB write of the heap limit register
    task automatic write_limit(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_HEAP_LIMIT;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_all_results();
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Response side: random stalls, one long hold-off
    initial
    begin
        int  hold;
        int  rsp_taken;
        bit  rsp_gaps;
        rsp_taken = 0;
        rsp_gaps  = 1'b1;
        rsp_stall <= 1'b1;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rsp_taken % 50 == 0) rsp_gaps = ($urandom_range(0, 3) != 0);
            if (rsp_taken == HOLD_AT) hold = HOLD_CYCLES;
            else hold = rsp_gaps ? $urandom_range(0, 16) : 0;
            repeat (hold)
            begin
                rsp_stall <= 1'b1;
                @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
            if (rsp.result_address != 0)
            begin
                live_addrs.push_back(rsp.result_address);
                if (live_addrs.size() > POOL_DEPTH) void'(live_addrs.pop_front());
            end
            rsp_taken++;
        end
    end

    // Watchdog: too long without any accepted transaction
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
            else quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int unsigned phase_limit [NUM_PHASES];
        int          phase_items [NUM_PHASES];
        int          free_pct    [NUM_PHASES];
        phase_limit = '{65536, 1024, 131071, 0, 4096, 0, 65536};
        phase_limit[5] = $urandom_range(0, 131071);
        phase_items = '{150, 150, 150, 50, 150, 150, 150};
        free_pct    = '{20, 25, 30, 70, 40, 25, 60};

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= REG_HEAP_LIMIT;
        pwdata    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corner cases from an empty heap at the reset limit
        send_req(pack_req(FUNC_ALLOC,   16'd0,     16'd0,     16'd0));     // zero-size alloc
        send_req(pack_req(FUNC_FREE,    16'd0,     16'd0,     16'd0));     // free of null
        send_req(pack_req(FUNC_FREE,    16'd0,     16'd0,     16'hFFFF));  // unknown address
        send_req(pack_req(FUNC_REALLOC, 16'd40,    16'hFFFF,  16'd0));     // realloc of null
        send_req(pack_req(FUNC_ALLOC,   16'd100,   16'd0,     16'd0));
        send_req(pack_req(FUNC_ALLOC,   16'd8,     16'd0,     16'd0));
        send_req(pack_req(FUNC_FREE,    16'd0,     16'd0,     16'd72));
        send_req(pack_req(FUNC_FREE,    16'd0,     16'd0,     16'd72));    // already free
        send_req(pack_req(FUNC_REALLOC, 16'd50,    16'd0,     16'd188));   // move, old is last
        send_req(pack_req(FUNC_REALLOC, 16'd90,    16'd0,     16'd72));    // fits in place
        send_req(pack_req(FUNC_REALLOC, 16'd5,     16'd0,     16'hFFFF));  // unknown address
        send_req(pack_req(FUNC_REALLOC, 16'd0,     16'd0,     16'd72));    // zero size
        send_req(pack_req(FUNC_CALLOC,  16'd5,     16'd0,     16'd0));     // zero count
        send_req(pack_req(FUNC_CALLOC,  16'd0,     16'd5,     16'd0));     // zero size
        send_req(pack_req(FUNC_CALLOC,  16'hFFFF,  16'hFFFF,  16'hFFFF));  // overflow
        send_req(pack_req(FUNC_CALLOC,  16'd256,   16'd256,   16'd0));     // product just over
        send_req(pack_req(FUNC_CALLOC,  16'd257,   16'd255,   16'd0));     // heap full
        send_req(pack_req(FUNC_CALLOC,  16'd4,     16'd3,     16'd0));
        send_req(pack_req(FUNC_ALLOC,   16'hFFFF,  16'd0,     16'd0));     // heap full
        send_req(pack_req(FUNC_REALLOC, 16'd65000, 16'd0,     16'd16));    // moves, appended at top
        send_req(pack_req(FUNC_FREE,    16'd0,     16'd0,     16'd188));   // marked free, not last
        send_req(pack_req(FUNC_FREE,    16'd0,     16'd0,     16'd17));    // misaligned
        send_req(pack_req(FUNC_FREE,    16'd0,     16'd0,     16'd16));
        send_req(pack_req(FUNC_ALLOC,   16'd40,    16'd0,     16'd0));     // reuses first block
        req_valid <= 1'b0;
        wait_all_results();

        // Random phases, each under its own heap limit
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_limit(phase_limit[p]);
            for (int k = 0; k < phase_items[p]; k++) send_req(make_item(free_pct[p]));
            req_valid <= 1'b0;
            wait_all_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
rtl/ffha_pkg.sv
rtl/first_fit_heap_allocator_unit.sv
bench/heap_alloc_checker.sv
bench/tb_top.sv
